// File: rtl/core/icls_pkg.sv
// shared constants, codes, command and status types for the circular list store
package icls_pkg;

    localparam int CAPACITY = 256;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;

    // free-slot search runs as two registered levels of 16
    localparam int GRP_BITS = 16;
    localparam int GRP_W    = $clog2(GRP_BITS);
    localparam int NUM_GRP  = CAPACITY / GRP_BITS;
    localparam int NGRP_W   = SLOT_W - GRP_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_AT   = 3'd0,
        OP_INS_LAST = 3'd1,
        OP_DEL_AT   = 3'd2,
        OP_DEL_LAST = 3'd3,
        OP_FIND     = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADIDX   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic    accept;
        logic    decode;
        logic    clear_all;
        logic    alloc_a;
        logic    alloc_b;
        logic    rd_link;
        logic    advance;
        logic    cap_head;
        logic    set_found;
        logic    ins_link;
        logic    ins_put;
        logic    del_head;
        logic    del_read;
        logic    del_fix;
        logic    load_out;
        status_t status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            full;
        logic            pos_gt_cnt;
        logic            pos_ge_cnt;
        logic            pos_zero;
        logic            walk_end;
        logic            match;
    } dp_stat_t;

    function automatic logic [GRP_W-1:0] lowest_set(input logic [GRP_BITS-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = GRP_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = GRP_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/icls_ctrl.sv
// sequencer for list operations: checks, slot allocation, chain walk, link updates
module icls_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  icls_pkg::dp_stat_t  stat,
    output icls_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_A,
        S_ALLOC_B,
        S_LOAD,
        S_STEP,
        S_INS_LINK,
        S_INS_PUT,
        S_DEL_HEAD,
        S_DEL_READ,
        S_DEL_FIX,
        S_REPLY
    } state_t;

    state_t              state_reg, state_next;
    icls_pkg::status_t   res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic                is_insert;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign is_insert = (stat.op == icls_pkg::OP_INS_AT) || (stat.op == icls_pkg::OP_INS_LAST);

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd             = '0;
        cmd.status      = res_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode      = 1'b1;
                res_status_next = icls_pkg::ST_OK;
                state_next      = S_REPLY;
                unique case (stat.op)
                    icls_pkg::OP_INS_AT: begin
                        if (stat.pos_gt_cnt) begin
                            res_status_next = icls_pkg::ST_BADIDX;
                        end else if (stat.full) begin
                            res_status_next = icls_pkg::ST_FULL;
                        end else begin
                            state_next = S_ALLOC_A;
                        end
                    end
                    icls_pkg::OP_INS_LAST: begin
                        if (stat.full) begin
                            res_status_next = icls_pkg::ST_FULL;
                        end else begin
                            state_next = S_ALLOC_A;
                        end
                    end
                    icls_pkg::OP_DEL_AT: begin
                        if (stat.pos_ge_cnt) begin
                            res_status_next = icls_pkg::ST_BADIDX;
                        end else begin
                            state_next = S_LOAD;
                        end
                    end
                    icls_pkg::OP_DEL_LAST: begin
                        if (stat.cnt_zero) begin
                            res_status_next = icls_pkg::ST_EMPTY;
                        end else begin
                            state_next = S_LOAD;
                        end
                    end
                    icls_pkg::OP_FIND: begin
                        if (stat.cnt_zero) begin
                            res_status_next = icls_pkg::ST_NOTFOUND;
                        end else begin
                            state_next = S_LOAD;
                        end
                    end
                    icls_pkg::OP_CLEAR: begin
                        cmd.clear_all = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC_A: begin
                cmd.alloc_a = 1'b1;
                state_next  = S_ALLOC_B;
            end
            S_ALLOC_B: begin
                cmd.alloc_b = 1'b1;
                // first entry needs no walk
                state_next  = stat.cnt_zero ? S_INS_PUT : S_LOAD;
            end
            S_LOAD: begin
                state_next = S_STEP;
            end
            S_STEP: begin
                if (stat.op == icls_pkg::OP_FIND) begin
                    if (stat.match) begin
                        cmd.set_found   = 1'b1;
                        res_status_next = icls_pkg::ST_OK;
                        state_next      = S_REPLY;
                    end else if (stat.walk_end) begin
                        res_status_next = icls_pkg::ST_NOTFOUND;
                        state_next      = S_REPLY;
                    end else begin
                        cmd.advance = 1'b1;
                        cmd.rd_link = 1'b1;
                    end
                end else begin
                    cmd.cap_head = !is_insert;
                    if (stat.walk_end) begin
                        if (is_insert) begin
                            state_next = S_INS_LINK;
                        end else begin
                            state_next = stat.pos_zero ? S_DEL_HEAD : S_DEL_READ;
                        end
                    end else begin
                        cmd.advance = 1'b1;
                        cmd.rd_link = 1'b1;
                    end
                end
            end
            S_INS_LINK: begin
                cmd.ins_link = 1'b1;
                state_next   = S_INS_PUT;
            end
            S_INS_PUT: begin
                cmd.ins_put     = 1'b1;
                res_status_next = icls_pkg::ST_OK;
                state_next      = S_REPLY;
            end
            S_DEL_HEAD: begin
                cmd.del_head    = 1'b1;
                res_status_next = icls_pkg::ST_OK;
                state_next      = S_REPLY;
            end
            S_DEL_READ: begin
                cmd.del_read = 1'b1;
                cmd.rd_link  = 1'b1;
                state_next   = S_DEL_FIX;
            end
            S_DEL_FIX: begin
                cmd.del_fix     = 1'b1;
                res_status_next = icls_pkg::ST_OK;
                state_next      = S_REPLY;
            end
            S_REPLY: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            res_status_reg <= icls_pkg::ST_OK;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // one item in flight: nothing taken until the result is handed over
    a_no_accept_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_result_only_from_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && $past(aresetn)) |=> (m_valid -> $past(state_reg == S_REPLY)))
        else $error("result raised outside reply state");

    a_walk_steps_not_find_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && stat.op == icls_pkg::OP_FIND) |-> !stat.match)
        else $error("walk advanced past a find match");

endmodule

// File: rtl/core/icls_dpath.sv
// slot and link stores, free map, chain walker and result registers
module icls_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  icls_pkg::ctl_cmd_t                  cmd,
    output icls_pkg::dp_stat_t                  stat,
    input  logic [icls_pkg::OP_W-1:0]           s_operation,
    input  logic signed [icls_pkg::VAL_W-1:0]   s_item_value,
    input  logic [icls_pkg::CNT_W-1:0]          s_position,
    output logic [icls_pkg::ST_W-1:0]           m_status,
    output logic signed [icls_pkg::VAL_W-1:0]   m_removed_value,
    output logic [icls_pkg::SLOT_W-1:0]         m_found_index,
    output logic [icls_pkg::CNT_W-1:0]          m_entry_count,
    output logic                                m_not_empty
);

    localparam int SW = icls_pkg::SLOT_W;
    localparam int CW = icls_pkg::CNT_W;
    localparam int VW = icls_pkg::VAL_W;

    logic [VW-1:0] value_mem [icls_pkg::CAPACITY];
    logic [SW-1:0] link_mem  [icls_pkg::CAPACITY];

    logic [icls_pkg::OP_W-1:0]   op_reg;
    logic [VW-1:0]               item_reg;
    logic [CW-1:0]               pos_reg;
    logic [CW-1:0]               count_reg;
    logic [SW-1:0]               head_reg;
    logic [icls_pkg::CAPACITY-1:0] free_reg;
    logic [icls_pkg::NGRP_W-1:0] grp_reg;
    logic [SW-1:0]               new_slot_reg;
    logic [SW-1:0]               slot_reg;
    logic [SW-1:0]               idx_reg;
    logic [SW-1:0]               target_reg;
    logic                        pos_zero_reg;
    logic [SW-1:0]               aux_link_reg;
    logic [SW-1:0]               aux_slot_reg;
    logic [VW-1:0]               removed_reg;
    logic [SW-1:0]               found_reg;
    logic [SW-1:0]               link_rd;
    logic [VW-1:0]               val_rd;

    logic [icls_pkg::ST_W-1:0]   m_status_reg;
    logic [VW-1:0]               m_removed_value_reg;
    logic [SW-1:0]               m_found_index_reg;
    logic [CW-1:0]               m_entry_count_reg;
    logic                        m_not_empty_reg;

    logic [CW-1:0]               cnt_m1;
    logic [CW-1:0]               eff_pos;
    logic [CW-1:0]               eff_m1;
    logic                        eff_zero;
    logic [icls_pkg::NUM_GRP-1:0] grp_any;
    logic [icls_pkg::GRP_BITS-1:0] grp_word;
    logic [SW-1:0]               rd_addr;
    logic                        link_we;
    logic [SW-1:0]               link_wa;
    logic [SW-1:0]               link_wd;

    assign cnt_m1 = count_reg - CW'(1);

    // position that the operation works on, with the end-based codes folded in
    always_comb begin
        unique case (op_reg)
            icls_pkg::OP_INS_LAST: eff_pos = count_reg;
            icls_pkg::OP_DEL_LAST: eff_pos = cnt_m1;
            default:               eff_pos = pos_reg;
        endcase
    end
    assign eff_m1   = eff_pos - CW'(1);
    assign eff_zero = (eff_pos == '0);

    always_comb begin
        for (int g = 0; g < icls_pkg::NUM_GRP; g++) begin
            grp_any[g] = |free_reg[g*icls_pkg::GRP_BITS +: icls_pkg::GRP_BITS];
        end
    end
    assign grp_word = free_reg[{grp_reg, icls_pkg::GRP_W'(0)} +: icls_pkg::GRP_BITS];

    assign rd_addr = cmd.rd_link ? link_rd : slot_reg;

    always_comb begin
        link_we = 1'b0;
        link_wa = slot_reg;
        link_wd = new_slot_reg;
        priority if (cmd.ins_link) begin
            link_we = 1'b1;
        end else if (cmd.ins_put) begin
            link_we = 1'b1;
            link_wa = new_slot_reg;
            if (count_reg == '0) begin
                link_wd = new_slot_reg;
            end else if (pos_zero_reg) begin
                link_wd = head_reg;
            end else begin
                link_wd = aux_link_reg;
            end
        end else if (cmd.del_head) begin
            link_we = 1'b1;
            link_wd = aux_link_reg;
        end else if (cmd.del_fix) begin
            link_we = 1'b1;
            link_wd = link_rd;
        end else begin
            link_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.ins_put) begin
            value_mem[new_slot_reg] <= item_reg;
        end
        link_rd <= link_mem[rd_addr];
        val_rd  <= value_mem[rd_addr];
    end

    // list control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            free_reg  <= '1;
        end else begin
            if (cmd.clear_all) begin
                count_reg <= '0;
                free_reg  <= '1;
            end
            if (cmd.ins_put) begin
                count_reg              <= count_reg + CW'(1);
                free_reg[new_slot_reg] <= 1'b0;
                if (count_reg == '0 || pos_zero_reg) begin
                    head_reg <= new_slot_reg;
                end
            end
            if (cmd.del_head) begin
                count_reg          <= cnt_m1;
                free_reg[head_reg] <= 1'b1;
                head_reg           <= aux_link_reg;
            end
            if (cmd.del_fix) begin
                count_reg              <= cnt_m1;
                free_reg[aux_slot_reg] <= 1'b1;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg      <= s_operation;
            item_reg    <= s_item_value;
            pos_reg     <= s_position;
            removed_reg <= '0;
            found_reg   <= '0;
        end
        if (cmd.decode) begin
            slot_reg     <= head_reg;
            idx_reg      <= '0;
            pos_zero_reg <= eff_zero;
            if (op_reg == icls_pkg::OP_FIND || eff_zero) begin
                target_reg <= cnt_m1[SW-1:0];
            end else begin
                target_reg <= eff_m1[SW-1:0];
            end
        end
        if (cmd.alloc_a) begin
            grp_reg <= icls_pkg::lowest_set(grp_any);
        end
        if (cmd.alloc_b) begin
            new_slot_reg <= {grp_reg, icls_pkg::lowest_set(grp_word)};
        end
        if (cmd.advance) begin
            slot_reg <= link_rd;
            idx_reg  <= idx_reg + SW'(1);
        end
        // head entry seen on the first step of a delete walk
        if (cmd.cap_head && idx_reg == '0) begin
            aux_link_reg <= link_rd;
            removed_reg  <= val_rd;
        end
        if (cmd.ins_link) begin
            aux_link_reg <= link_rd;
        end
        if (cmd.del_read) begin
            aux_slot_reg <= link_rd;
        end
        if (cmd.del_fix) begin
            removed_reg <= val_rd;
        end
        if (cmd.set_found) begin
            found_reg <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg        <= cmd.status;
            m_removed_value_reg <= removed_reg;
            m_found_index_reg   <= found_reg;
            m_entry_count_reg   <= count_reg;
            m_not_empty_reg     <= (count_reg != '0);
        end
    end

    assign stat.op         = op_reg;
    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(icls_pkg::CAPACITY));
    assign stat.pos_gt_cnt = (pos_reg > count_reg);
    assign stat.pos_ge_cnt = (pos_reg >= count_reg);
    assign stat.pos_zero   = pos_zero_reg;
    assign stat.walk_end   = (idx_reg == target_reg);
    assign stat.match      = (val_rd == item_reg);

    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_value_reg;
    assign m_found_index   = m_found_index_reg;
    assign m_entry_count   = m_entry_count_reg;
    assign m_not_empty     = m_not_empty_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(icls_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_free_map_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(count_reg) + $countones(free_reg)) == icls_pkg::CAPACITY)
        else $error("free map out of step with entry count");

    a_alloc_slot_is_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_put |-> free_reg[new_slot_reg])
        else $error("insert into a slot already in use");

endmodule

// File: rtl/core/indexed_circular_list_store.sv
// top level of the indexed circular list store
// An ordered list of up to 256 signed 32-bit entries held as a circular chain of
// slots; each item carries one operation and yields exactly one result item.
// One item is worked at a time, and the next is taken while the previous result
// still waits in the output register. Clear, unused codes and rejected requests
// go from decode straight to the reply; an insert into an empty list allocates
// a slot and writes it with no walk; other inserts and all deletes first walk
// k chain hops to the slot before the target (the tail for index 0), up to 254
// for an insert and 255 for a delete; find walks from the head until a match or
// the tail. The chain walk reads the link store once a cycle through a single
// registered read port, and that walk sets the worst case. A new entry takes the
// lowest free slot, found by a two-level search over the free map.
module indexed_circular_list_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [icls_pkg::OP_W-1:0]           s_operation,
    input  logic signed [icls_pkg::VAL_W-1:0]   s_item_value,
    input  logic [icls_pkg::CNT_W-1:0]          s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [icls_pkg::ST_W-1:0]           m_status,
    output logic signed [icls_pkg::VAL_W-1:0]   m_removed_value,
    output logic [icls_pkg::SLOT_W-1:0]         m_found_index,
    output logic [icls_pkg::CNT_W-1:0]          m_entry_count,
    output logic                                m_not_empty
);

    icls_pkg::ctl_cmd_t cmd;
    icls_pkg::dp_stat_t stat;

    icls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    icls_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_operation     (s_operation),
        .s_item_value    (s_item_value),
        .s_position      (s_position),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_found_index   (m_found_index),
        .m_entry_count   (m_entry_count),
        .m_not_empty     (m_not_empty)
    );

endmodule

// File: tb/sv/indexed_circular_list_store_test.sv
// self-checking testbench for the indexed circular list store
module indexed_circular_list_store_test;

    localparam logic [icls_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [icls_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int HOLD_CYCLES    = 700;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        icls_pkg::status_t                 status;
        logic signed [icls_pkg::VAL_W-1:0] removed_value;
        logic [icls_pkg::SLOT_W-1:0]       found_index;
        logic [icls_pkg::CNT_W-1:0]        entry_count;
        logic                              not_empty;
    } list_result_t;

    // keeps the list contents in order and the results they must produce
    class list_scoreboard;
        logic signed [icls_pkg::VAL_W-1:0] entries[$];
        list_result_t                      pending_results[$];
        int                                errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(logic [icls_pkg::OP_W-1:0] op,
                                logic signed [icls_pkg::VAL_W-1:0] val,
                                logic [icls_pkg::CNT_W-1:0] pos);
            list_result_t r;
            int unsigned  cnt;
            cnt             = entries.size();
            r.status        = icls_pkg::ST_OK;
            r.removed_value = '0;
            r.found_index   = '0;
            case (op)
                icls_pkg::OP_INS_AT: begin
                    // bad index wins over full
                    if (pos > cnt) begin
                        r.status = icls_pkg::ST_BADIDX;
                    end else if (cnt >= icls_pkg::CAPACITY) begin
                        r.status = icls_pkg::ST_FULL;
                    end else if (pos == cnt) begin
                        entries.push_back(val);
                    end else begin
                        entries.insert(int'(pos), val);
                    end
                end
                icls_pkg::OP_INS_LAST: begin
                    if (cnt >= icls_pkg::CAPACITY) begin
                        r.status = icls_pkg::ST_FULL;
                    end else begin
                        entries.push_back(val);
                    end
                end
                icls_pkg::OP_DEL_AT: begin
                    if (pos >= cnt) begin
                        r.status = icls_pkg::ST_BADIDX;
                    end else begin
                        r.removed_value = entries[pos];
                        entries.delete(int'(pos));
                    end
                end
                icls_pkg::OP_DEL_LAST: begin
                    if (cnt == 0) begin
                        r.status = icls_pkg::ST_EMPTY;
                    end else begin
                        r.removed_value = entries.pop_back();
                    end
                end
                icls_pkg::OP_FIND: begin
                    r.status = icls_pkg::ST_NOTFOUND;
                    for (int i = 0; i < entries.size(); i++) begin
                        if (entries[i] == val) begin
                            r.status      = icls_pkg::ST_OK;
                            r.found_index = icls_pkg::SLOT_W'(i);
                            break;
                        end
                    end
                end
                icls_pkg::OP_CLEAR: begin
                    entries.delete();
                end
                default: begin
                end
            endcase
            r.entry_count = icls_pkg::CNT_W'(entries.size());
            r.not_empty   = (entries.size() != 0);
            pending_results.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t exp;
            if (pending_results.size() == 0) begin
                $display("%0t: result item with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.removed_value !== exp.removed_value) begin
                $display("%0t: removed_value expected %0d actual %0d", $time,
                         exp.removed_value, got.removed_value);
                errors++;
            end
            if (got.found_index !== exp.found_index) begin
                $display("%0t: found_index expected %0d actual %0d", $time,
                         exp.found_index, got.found_index);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time,
                         exp.entry_count, got.entry_count);
                errors++;
            end
            if (got.not_empty !== exp.not_empty) begin
                $display("%0t: not_empty expected %0b actual %0b", $time,
                         exp.not_empty, got.not_empty);
                errors++;
            end
        endfunction
    endclass

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [icls_pkg::OP_W-1:0]          s_operation = '0;
    logic signed [icls_pkg::VAL_W-1:0]  s_item_value = '0;
    logic [icls_pkg::CNT_W-1:0]         s_position = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [icls_pkg::ST_W-1:0]          m_status;
    logic signed [icls_pkg::VAL_W-1:0]  m_removed_value;
    logic [icls_pkg::SLOT_W-1:0]        m_found_index;
    logic [icls_pkg::CNT_W-1:0]         m_entry_count;
    logic                               m_not_empty;

    list_scoreboard sb;
    bit             hold_req = 1'b0;
    bit             send_steady = 1'b0;
    int             idle_cycles = 0;

    indexed_circular_list_store i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_item_value    (s_item_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_found_index   (m_found_index),
        .m_entry_count   (m_entry_count),
        .m_not_empty     (m_not_empty)
    );

    always #6 aclk = ~aclk;

    // offers one item and notes it once accepted
    task automatic send_item(logic [icls_pkg::OP_W-1:0] op,
                             logic signed [icls_pkg::VAL_W-1:0] val,
                             logic [icls_pkg::CNT_W-1:0] pos);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_steady = !send_steady;
        end
        gap = send_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_item_value <= val;
        s_position   <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, val, pos);
    endtask

    function automatic logic signed [icls_pkg::VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            // small pool so that duplicates show up
            case ($urandom_range(0, 5))
                0:       return 32'sd1;
                1:       return 32'sd2;
                2:       return 32'sd3;
                3:       return -32'sd7;
                4:       return 32'sd100;
                default: return 32'sd42;
            endcase
        end else if (sel < 9) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [icls_pkg::VAL_W-1:0] search_value();
        if (sb.entries.size() > 0 && $urandom_range(0, 2) != 0) begin
            return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
        end
        return pick_value();
    endfunction

    function automatic logic [icls_pkg::CNT_W-1:0] pick_pos(int cnt);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return icls_pkg::CNT_W'($urandom_range(0, cnt + 1));
        end else if (sel == 7) begin
            return icls_pkg::CNT_W'(cnt);
        end else if (sel == 8) begin
            return (cnt == 0) ? '0 : icls_pkg::CNT_W'(cnt - 1);
        end
        return icls_pkg::CNT_W'($urandom_range(0, 511));
    endfunction

    // random operations that keep the list short, so walks stay cheap
    task automatic run_mixed(int n, bit with_hold);
        int                        cnt;
        int                        r;
        int                        ins_w;
        int                        del_w;
        logic [icls_pkg::OP_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            cnt = sb.entries.size();
            r   = $urandom_range(0, 99);
            if (cnt < 4) begin
                ins_w = 50;
                del_w = 20;
            end else if (cnt > 24) begin
                ins_w = 20;
                del_w = 50;
            end else begin
                ins_w = 38;
                del_w = 37;
            end
            if (r < ins_w) begin
                op = $urandom_range(0, 1) ? icls_pkg::OP_INS_AT : icls_pkg::OP_INS_LAST;
            end else if (r < ins_w + del_w) begin
                op = $urandom_range(0, 1) ? icls_pkg::OP_DEL_AT : icls_pkg::OP_DEL_LAST;
            end else if (r < 95) begin
                op = icls_pkg::OP_FIND;
            end else if (r < 97) begin
                op = icls_pkg::OP_CLEAR;
            end else begin
                op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            end
            send_item(op, (op == icls_pkg::OP_FIND) ? search_value() : pick_value(),
                      pick_pos(cnt));
            if (with_hold && i == n / 4) begin
                hold_req = 1'b1;
            end
        end
    endtask

    // grow to capacity, then work the full list at its deep end
    task automatic run_fill();
        int cnt;
        while (sb.entries.size() < icls_pkg::CAPACITY) begin
            cnt = sb.entries.size();
            if ($urandom_range(0, 1)) begin
                send_item(icls_pkg::OP_INS_AT, pick_value(),
                          icls_pkg::CNT_W'($urandom_range(0, cnt)));
            end else begin
                send_item(icls_pkg::OP_INS_LAST, pick_value(),
                          icls_pkg::CNT_W'($urandom_range(0, 511)));
            end
            if ($urandom_range(0, 15) == 0) begin
                send_item(icls_pkg::OP_FIND, search_value(), '0);
            end
        end
        send_item(icls_pkg::OP_INS_LAST, pick_value(), '0);
        send_item(icls_pkg::OP_INS_AT, pick_value(), icls_pkg::CNT_W'(icls_pkg::CAPACITY));
        send_item(icls_pkg::OP_INS_AT, pick_value(), icls_pkg::CNT_W'(icls_pkg::CAPACITY + 1));
        send_item(icls_pkg::OP_INS_AT, pick_value(), '1);
        send_item(icls_pkg::OP_FIND, sb.entries[icls_pkg::CAPACITY-1], '0);
        send_item(icls_pkg::OP_DEL_AT, '0, icls_pkg::CNT_W'(icls_pkg::CAPACITY - 1));
        send_item(icls_pkg::OP_INS_LAST, 32'sh5a5a_c3c3, '0);
        send_item(icls_pkg::OP_FIND, 32'sh5a5a_c3c3, '0);
        send_item(icls_pkg::OP_DEL_AT, '0, '0);
        send_item(icls_pkg::OP_INS_AT, pick_value(), '0);
        send_item(icls_pkg::OP_DEL_LAST, '0, '0);
        send_item(icls_pkg::OP_INS_AT, pick_value(), icls_pkg::CNT_W'(icls_pkg::CAPACITY - 1));
        send_item(icls_pkg::OP_DEL_AT, '0, icls_pkg::CNT_W'(icls_pkg::CAPACITY / 2));
        for (int i = 0; i < 12; i++) begin
            cnt = sb.entries.size();
            send_item(icls_pkg::OP_DEL_AT, '0, icls_pkg::CNT_W'($urandom_range(0, cnt - 1)));
        end
        send_item(icls_pkg::OP_FIND, 32'sh5a5a_c3c3, '0);
        send_item(icls_pkg::OP_CLEAR, '0, '0);
    endtask

    // result side: random hold-offs plus one long stall on request
    initial begin : result_sink
        int gap;
        bit steady;
        steady = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                steady = !steady;
            end
            gap = steady ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        list_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status        = icls_pkg::status_t'(m_status);
                got.removed_value = m_removed_value;
                got.found_index   = m_found_index;
                got.entry_count   = m_entry_count;
                got.not_empty     = m_not_empty;
                sb.check_result(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list corner cases
        send_item(icls_pkg::OP_DEL_LAST, '0, '0);
        send_item(icls_pkg::OP_DEL_AT, '0, '0);
        send_item(icls_pkg::OP_FIND, 32'sd0, '0);
        send_item(icls_pkg::OP_INS_AT, 32'sd9, 9'd1);
        // build a short list through each insert path
        send_item(icls_pkg::OP_INS_AT, 32'sh8000_0000, '0);
        send_item(icls_pkg::OP_INS_LAST, 32'sh7fff_ffff, '0);
        send_item(icls_pkg::OP_INS_AT, 32'sd0, 9'd1);
        send_item(icls_pkg::OP_INS_AT, -32'sd1, '0);
        send_item(icls_pkg::OP_INS_AT, 32'sd5, 9'd4);
        send_item(icls_pkg::OP_INS_AT, 32'sd6, '1);
        send_item(icls_pkg::OP_FIND, 32'sd0, '0);
        send_item(icls_pkg::OP_FIND, -32'sd1, '0);
        send_item(icls_pkg::OP_FIND, 32'sd5, '0);
        send_item(icls_pkg::OP_FIND, 32'sd12345, '0);
        send_item(OP_SPARE_6, 32'sd1, 9'd3);
        send_item(OP_SPARE_7, -32'sd1, '1);
        send_item(icls_pkg::OP_DEL_AT, '0, '0);
        send_item(icls_pkg::OP_DEL_AT, '0, 9'd3);
        send_item(icls_pkg::OP_DEL_AT, '0, 9'd1);
        send_item(icls_pkg::OP_DEL_AT, '0, '1);
        send_item(icls_pkg::OP_DEL_LAST, '0, '0);
        send_item(icls_pkg::OP_CLEAR, '0, '0);
        send_item(icls_pkg::OP_INS_LAST, 32'sh1234_5678, '0);
        send_item(icls_pkg::OP_CLEAR, '0, '0);
        send_item(icls_pkg::OP_CLEAR, '0, '0);

        run_mixed(260, 1'b1);
        run_fill();
        run_mixed(250, 1'b0);

        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
